[rtl/escaped_frame_builder_crc16_assert.svh]
// assertion macros for the escaped frame builder
`ifndef ESCAPED_FRAME_BUILDER_CRC16_ASSERT_SVH
`define ESCAPED_FRAME_BUILDER_CRC16_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define EFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/efb_pkg.sv]
// shared types, constants and crc function of the escaped frame builder
package efb_pkg;

    localparam logic [7:0]  START_BYTE     = 8'h55;
    localparam logic [7:0]  ESC_BYTE       = 8'hAA;
    localparam logic [7:0]  ESC_TAIL_START = 8'h00;
    localparam logic [7:0]  ESC_TAIL_ESC   = 8'h01;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  FRAME_LEN_RST  = 8'd128;

    // one classified item handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  len;
        logic        first;
        logic        last;
        logic [15:0] crc;
    } t_item;

    // crc-16/modbus update by one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/efb_front.sv]
// front part: accepts samples, tracks frame position and crc, classifies items
module efb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_in_valid,
    input  logic [7:0]    i_sample,
    input  logic          i_q_full,
    output logic          o_in_stall,
    output logic          o_push,
    output efb_pkg::t_item o_item
);
    import efb_pkg::*;

    logic [7:0]  r_frame_len;
    logic [15:0] r_len_crc;
    logic [7:0]  r_idx;
    logic [15:0] r_crc;
    logic [15:0] crc_in;
    logic [15:0] crc_new;
    logic        first;
    logic        last;
    logic        accept;

    // length register with crc of the length byte kept alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RST;
            r_len_crc   <= crc_byte(CRC_INIT, FRAME_LEN_RST);
        end else if (i_cfg_we) begin
            r_frame_len <= i_cfg_wdata;
            r_len_crc   <= crc_byte(CRC_INIT, i_cfg_wdata);
        end
    end

    // classify the incoming sample
    always_comb begin
        first   = (r_idx == 8'd0);
        crc_in  = first ? r_len_crc : r_crc;
        crc_new = crc_byte(crc_in, i_sample);
        if (r_frame_len == 8'd0) begin
            last = (r_idx == 8'hFF);
        end else begin
            last = (({1'b0, r_idx} + 9'd1) >= {1'b0, r_frame_len});
        end
    end

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        o_item.data  = i_sample;
        o_item.len   = r_frame_len;
        o_item.first = first;
        o_item.last  = last;
        o_item.crc   = crc_new;
    end

    // frame position and running crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 8'd0;
            r_crc <= CRC_INIT;
        end else if (accept) begin
            if (last) begin
                r_idx <= 8'd0;
                r_crc <= CRC_INIT;
            end else begin
                r_idx <= r_idx + 8'd1;
                r_crc <= crc_new;
            end
        end
    end

endmodule

[rtl/efb_queue.sv]
// short item queue between front and back
module efb_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  efb_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output efb_pkg::t_item o_head
);
    import efb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[rtl/efb_back.sv]
// back part: byte sequencer with escaping and registered output
module efb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  efb_pkg::t_item i_head,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_frame_end
);
    import efb_pkg::*;

    `include "escaped_frame_builder_crc16_assert.svh"

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRCH  = 3'd4;
    localparam logic [2:0] PH_CRCL  = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic       r_esc2, n_esc2;
    logic       r_esc_tail, n_esc_tail;
    t_item      r_item, n_item;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_run_last, n_run_last;
    logic       r_frame_end, n_frame_end;

    logic [7:0] raw;
    logic       active;
    logic       can_emit;
    logic       fire;
    logic       needs_esc;
    logic       advance;
    logic       finishing;
    logic       pop;
    logic [2:0] load_phase;
    logic [2:0] step_phase;

    // raw byte for the current phase
    always_comb begin
        unique case (r_phase)
            PH_START: raw = START_BYTE;
            PH_LEN:   raw = r_item.len;
            PH_DATA:  raw = r_item.data;
            PH_CRCH:  raw = r_item.crc[15:8];
            PH_CRCL:  raw = r_item.crc[7:0];
            default:  raw = 8'h00;
        endcase
    end

    // phase after the current one within an item
    always_comb begin
        unique case (r_phase)
            PH_START: step_phase = PH_LEN;
            PH_LEN:   step_phase = PH_DATA;
            PH_DATA:  step_phase = PH_CRCH;
            PH_CRCH:  step_phase = PH_CRCL;
            default:  step_phase = PH_IDLE;
        endcase
    end

    // emit control
    always_comb begin
        active     = (r_phase != PH_IDLE);
        can_emit   = !r_out_valid || !i_out_stall;
        fire       = active && can_emit;
        needs_esc  = (r_phase != PH_START) && ((raw == START_BYTE) || (raw == ESC_BYTE));
        advance    = fire && (r_esc2 || !needs_esc);
        finishing  = advance && ((r_phase == PH_CRCL) || ((r_phase == PH_DATA) && !r_item.last));
        pop        = (!active || finishing) && !i_q_empty;
        load_phase = i_head.first ? PH_START : PH_DATA;
    end

    assign o_pop = pop;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_esc2      = r_esc2;
        n_esc_tail  = r_esc_tail;
        n_item      = r_item;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_run_last  = r_run_last;
        n_frame_end = r_frame_end;

        if (fire) begin
            n_out_valid = 1'b1;
            n_run_last  = finishing;
            n_frame_end = finishing && (r_phase == PH_CRCL);
            if (r_esc2) begin
                n_out_byte = r_esc_tail ? ESC_TAIL_ESC : ESC_TAIL_START;
                n_esc2     = 1'b0;
            end else if (needs_esc) begin
                n_out_byte = ESC_BYTE;
                n_esc2     = 1'b1;
                n_esc_tail = (raw == ESC_BYTE);
            end else begin
                n_out_byte = raw;
            end
        end else if (can_emit) begin
            n_out_valid = 1'b0;
        end

        if (advance) begin
            n_phase = step_phase;
        end
        if (finishing) begin
            n_phase = PH_IDLE;
        end
        if (pop) begin
            n_phase = load_phase;
            n_item  = i_head;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_esc2      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_esc2      <= n_esc2;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_esc_tail  <= n_esc_tail;
        r_item      <= n_item;
        r_out_byte  <= n_out_byte;
        r_run_last  <= n_run_last;
        r_frame_end <= n_frame_end;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_frame_end = r_frame_end;

    // checks
    `EFB_ASSERT_NOW(a_end_is_last, r_out_valid && r_frame_end, r_run_last, "frame end without run end")
    `EFB_ASSERT_NOW(a_esc_in_item, r_esc2, r_phase != PH_IDLE, "escape tail pending while idle")
    `EFB_ASSERT_NOW(a_esc_follows, r_esc2, r_out_valid && (r_out_byte == ESC_BYTE), "escape tail without escape byte")

endmodule

[rtl/escaped_frame_builder_crc16.sv]
// Escaped frame builder: packs 8-bit samples into frames of frame_len samples
// (0 means 256), each opened by 0x55 and the escaped length byte and closed by
// the escaped CRC-16/MODBUS (high byte first) over length and data; 0x55 goes
// out as AA 00 and 0xAA as AA 01. The front takes one sample per cycle while the
// item queue has room; the back sequencer sends one output byte per cycle unless
// the output is stalled. An item gives 1 to 9 bytes and is loaded before its
// first byte when the sequencer is idle, else as the last byte of the one ahead
// goes out. The user writes the length register with i_cfg_we only while the
// block is idle; the block itself does not enforce this.
module escaped_frame_builder_crc16 #(
    parameter int QDEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_sample,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_frame_end
);
    import efb_pkg::*;

    t_item push_item;
    t_item head_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    // front: accept and classify
    efb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_sample    (i_sample),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_item      (push_item)
    );

    // item queue
    efb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_item)
    );

    // back: byte sequencer
    efb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head_item),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

endmodule
